FILE: src/fhp_pkg.sv
// Package for the frame header parser: header geometry, tail sizes, status codes
// and the types that pass between the capture and result stages. No dependencies.
package fhp_pkg;

    localparam int HDR_BYTES = 44;
    localparam int SUM_BYTES = 31;
    localparam int TAIL_LONG = 4;
    localparam int TAIL_SHORT = 2;
    localparam int POS_W = $clog2(HDR_BYTES + 1);

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_BAD_START = 3'd2,
        ST_BAD_HLEN  = 3'd3,
        ST_BAD_SUM   = 3'd4,
        ST_BAD_PLEN  = 3'd5
    } t_status;

    typedef logic [HDR_BYTES-1:0][7:0] t_hdr;

    typedef struct packed {
        logic valid;
        logic short_hdr;
    } t_pend;

endpackage

FILE: src/frame_header_parser.sv
// Frame header parser top level: APB register file, capture stage and result stage.
// Depends on fhp_pkg, fhp_capture and fhp_result.
//
// Usage: bytes of a receive buffer enter one per transaction on i_valid/o_ready with
// i_first_byte marking the start of a buffer and i_last_byte its final byte. Each
// buffer yields one result transaction on o_valid/i_ready: after header byte 43, or
// at the last byte of a buffer shorter than the header (status short). Bytes before
// the first marked byte and after the header are dropped without a result.
// A finished header waits in the capture stage until the output register is free, then
// loads the output register, which raises o_valid.
// Throughput: one byte per cycle; the input stalls only while a finished header waits
// and the output register still holds an untaken result.
// Reset (synchronous, i_rst_n low) empties both stages, returns the parser to waiting
// for a first byte and loads start_byte = 2, check_packet_mask = 1.
// Registers: start_byte at 0x0, check_packet_mask at 0x4; write only while idle.
module frame_header_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [15:0] o_pkt_len,
    output logic [7:0]  o_proto_ver,
    output logic [15:0] o_frame_opt,
    output logic [63:0] o_dest_address,
    output logic [39:0] o_source_address,
    output logic [31:0] o_frame_number,
    output logic [31:0] o_access_code,
    output logic [15:0] o_command_word,
    output logic [23:0] o_item_word,
    output logic [63:0] o_block_info,
    output logic [15:0] o_payload_length,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fhp_pkg::*;

    localparam logic REG_START = 1'b0;
    localparam logic REG_MASK  = 1'b1;

    logic [7:0]  r_start_byte;
    logic [15:0] r_check_packet_mask;

    logic        w_wr;
    logic        w_accept;
    logic        w_take;
    t_hdr        w_hdr;
    logic [7:0]  w_xor_sum;
    t_pend       w_pend;

    assign pready   = 1'b1;
    assign w_wr     = psel && penable && pwrite;
    assign prdata   = (paddr[2] == REG_MASK) ? {16'd0, r_check_packet_mask}
                                             : {24'd0, r_start_byte};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte        <= 8'd2;
            r_check_packet_mask <= 16'd1;
        end else if (w_wr) begin
            if (paddr[2] == REG_START) begin
                r_start_byte <= pwdata[7:0];
            end else begin
                r_check_packet_mask <= pwdata[15:0];
            end
        end
    end

    assign o_ready  = !w_pend.valid || w_take;
    assign w_accept = i_valid && o_ready;

    fhp_capture u_capture (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_data_byte  (i_data_byte),
        .i_first_byte (i_first_byte),
        .i_last_byte  (i_last_byte),
        .i_take       (w_take),
        .o_hdr        (w_hdr),
        .o_xor_sum    (w_xor_sum),
        .o_pend       (w_pend)
    );

    fhp_result u_result (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_hdr               (w_hdr),
        .i_xor_sum           (w_xor_sum),
        .i_pend              (w_pend),
        .i_start_byte        (r_start_byte),
        .i_check_packet_mask (r_check_packet_mask),
        .i_ready             (i_ready),
        .o_take              (w_take),
        .o_valid             (o_valid),
        .o_status            (o_status),
        .o_pkt_len           (o_pkt_len),
        .o_proto_ver         (o_proto_ver),
        .o_frame_opt         (o_frame_opt),
        .o_dest_address      (o_dest_address),
        .o_source_address    (o_source_address),
        .o_frame_number      (o_frame_number),
        .o_access_code       (o_access_code),
        .o_command_word      (o_command_word),
        .o_item_word         (o_item_word),
        .o_block_info        (o_block_info),
        .o_payload_length    (o_payload_length)
    );

endmodule

FILE: src/fhp_capture.sv
// Capture stage: byte position, running XOR over the checksum span and the header bytes.
// Flags a finished header (or an early end) for the result stage. Uses fhp_pkg.
module fhp_capture (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_accept,
    input  logic [7:0]   i_data_byte,
    input  logic         i_first_byte,
    input  logic         i_last_byte,
    input  logic         i_take,
    output fhp_pkg::t_hdr o_hdr,
    output logic [7:0]   o_xor_sum,
    output fhp_pkg::t_pend o_pend
);
    import fhp_pkg::*;

    logic [POS_W-1:0] r_pos;
    logic             r_finished;
    logic [7:0]       r_xor;
    t_hdr             r_hdr;
    logic             r_pend_valid;
    logic             r_short;

    logic             w_active;
    logic [POS_W-1:0] w_base;
    logic [POS_W-1:0] w_idx;
    logic [POS_W-1:0] n_pos;
    logic [7:0]       n_xor;
    logic             w_done;

    always_comb begin
        w_active = i_first_byte || !r_finished;
        w_base   = i_first_byte ? '0 : r_pos;
        w_idx    = (w_base >= POS_W'(HDR_BYTES)) ? '0 : w_base;
        n_pos    = w_idx + POS_W'(1);
        w_done   = (n_pos == POS_W'(HDR_BYTES)) || i_last_byte;
        n_xor    = (i_first_byte ? 8'd0 : r_xor)
                 ^ ((w_idx < POS_W'(SUM_BYTES)) ? i_data_byte : 8'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_finished   <= 1'b1;
            r_xor        <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            if (i_accept && w_active) begin
                r_pos      <= n_pos;
                r_xor      <= n_xor;
                r_finished <= w_done;
            end
            if (i_accept && w_active && w_done) begin
                r_pend_valid <= 1'b1;
            end else if (i_take) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && w_active) begin
            r_hdr[w_idx] <= i_data_byte;
            r_short      <= (n_pos < POS_W'(HDR_BYTES));
        end
    end

    assign o_hdr            = r_hdr;
    assign o_xor_sum        = r_xor;
    assign o_pend.valid     = r_pend_valid;
    assign o_pend.short_hdr = r_short;

endmodule

FILE: src/fhp_result.sv
// Result stage: header checks, big-endian field extraction and the output register.
// Takes the captured header from fhp_capture. Uses fhp_pkg.
module fhp_result (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  fhp_pkg::t_hdr i_hdr,
    input  logic [7:0]    i_xor_sum,
    input  fhp_pkg::t_pend i_pend,
    input  logic [7:0]    i_start_byte,
    input  logic [15:0]   i_check_packet_mask,
    input  logic          i_ready,
    output logic          o_take,
    output logic          o_valid,
    output logic [2:0]    o_status,
    output logic [15:0]   o_pkt_len,
    output logic [7:0]    o_proto_ver,
    output logic [15:0]   o_frame_opt,
    output logic [63:0]   o_dest_address,
    output logic [39:0]   o_source_address,
    output logic [31:0]   o_frame_number,
    output logic [31:0]   o_access_code,
    output logic [15:0]   o_command_word,
    output logic [23:0]   o_item_word,
    output logic [63:0]   o_block_info,
    output logic [15:0]   o_payload_length
);
    import fhp_pkg::*;

    logic        r_valid;
    logic [2:0]  r_status;
    logic [15:0] r_pkt_len;
    logic [7:0]  r_proto_ver;
    logic [15:0] r_frame_opt;
    logic [63:0] r_dest_address;
    logic [39:0] r_source_address;
    logic [31:0] r_frame_number;
    logic [31:0] r_access_code;
    logic [15:0] r_command_word;
    logic [23:0] r_item_word;
    logic [63:0] r_block_info;
    logic [15:0] r_payload_length;

    logic [15:0] w_plen;
    logic [15:0] w_fopt;
    logic [15:0] w_limit;
    t_status     n_status;
    logic        w_ok;

    always_comb begin
        w_plen  = {i_hdr[1], i_hdr[2]};
        w_fopt  = {i_hdr[4], i_hdr[5]};
        w_limit = ((w_fopt & i_check_packet_mask) != 16'd0)
                ? 16'(HDR_BYTES + TAIL_LONG) : 16'(HDR_BYTES + TAIL_SHORT);
        if (i_pend.short_hdr) begin
            n_status = ST_SHORT;
        end else if (i_hdr[0] != i_start_byte) begin
            n_status = ST_BAD_START;
        end else if (i_hdr[6] != 8'(HDR_BYTES)) begin
            n_status = ST_BAD_HLEN;
        end else if (i_xor_sum != i_hdr[SUM_BYTES]) begin
            n_status = ST_BAD_SUM;
        end else if (w_plen < w_limit) begin
            n_status = ST_BAD_PLEN;
        end else begin
            n_status = ST_OK;
        end
        w_ok   = (n_status == ST_OK);
        o_take = i_pend.valid && (!r_valid || i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_status           <= n_status;
            r_pkt_len          <= w_ok ? w_plen : '0;
            r_proto_ver        <= w_ok ? i_hdr[3] : '0;
            r_frame_opt        <= w_ok ? w_fopt : '0;
            r_dest_address     <= w_ok ? {i_hdr[7], i_hdr[8], i_hdr[9], i_hdr[10],
                                          i_hdr[11], i_hdr[12], i_hdr[13], i_hdr[14]} : '0;
            r_source_address   <= w_ok ? {i_hdr[15], i_hdr[16], i_hdr[17], i_hdr[18],
                                          i_hdr[19]} : '0;
            r_frame_number     <= w_ok ? {i_hdr[20], i_hdr[21], i_hdr[22], i_hdr[23]} : '0;
            r_access_code      <= w_ok ? {i_hdr[24], i_hdr[25], i_hdr[26], i_hdr[27]} : '0;
            r_command_word     <= w_ok ? {i_hdr[29], i_hdr[30]} : '0;
            r_item_word        <= w_ok ? {i_hdr[33], i_hdr[34], i_hdr[35]} : '0;
            r_block_info       <= w_ok ? {i_hdr[36], i_hdr[37], i_hdr[38], i_hdr[39],
                                          i_hdr[40], i_hdr[41], i_hdr[42], i_hdr[43]} : '0;
            r_payload_length   <= w_ok ? (w_plen - w_limit) : '0;
        end
    end

    assign o_valid            = r_valid;
    assign o_status           = r_status;
    assign o_pkt_len          = r_pkt_len;
    assign o_proto_ver        = r_proto_ver;
    assign o_frame_opt        = r_frame_opt;
    assign o_dest_address     = r_dest_address;
    assign o_source_address   = r_source_address;
    assign o_frame_number     = r_frame_number;
    assign o_access_code      = r_access_code;
    assign o_command_word     = r_command_word;
    assign o_item_word        = r_item_word;
    assign o_block_info       = r_block_info;
    assign o_payload_length   = r_payload_length;

endmodule

FILE: test/frame_header_parser_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for frame_header_parser: byte stream in, one header result per buffer.
// Depends on fhp_pkg and the frame_header_parser RTL; carries its own header parser model.
module frame_header_parser_tb;
    import fhp_pkg::*;

    localparam logic [2:0] REG_START_BYTE = 3'h0;
    localparam logic [2:0] REG_CHECK_MASK = 3'h4;
    localparam int SETTLE_CYCLES = 8;

    typedef enum logic [1:0] {
        FILL_RAND,
        FILL_ZERO,
        FILL_ONES
    } t_fill;

    typedef struct packed {
        logic [7:0]  b0;
        logic [7:0]  hlen;
        logic [15:0] plen;
        logic [15:0] fopt;
        logic [7:0]  flip;
        logic [5:0]  len;
        logic        mark_last;
        logic [1:0]  trail;
        logic [1:0]  lead;
        t_fill       fill;
        logic        typed;
        t_status     status;
    } t_buf_row;

    typedef struct packed {
        t_status     status;
        logic [15:0] pkt_len;
        logic [7:0]  proto_ver;
        logic [15:0] frame_opt;
        logic [63:0] dest_address;
        logic [39:0] source_address;
        logic [31:0] frame_number;
        logic [31:0] access_code;
        logic [15:0] command_word;
        logic [23:0] item_word;
        logic [63:0] block_info;
        logic [15:0] payload_length;
    } t_fields;

    localparam t_buf_row DIR_ROWS [16] = '{
        '{8'h02, 8'd44, 16'd100,   16'h0001, 8'h00, 6'd44, 1'b0, 2'd2, 2'd3, FILL_RAND, 1'b0, ST_OK},
        '{8'h02, 8'd44, 16'd46,    16'h0000, 8'h00, 6'd44, 1'b0, 2'd0, 2'd0, FILL_ZERO, 1'b0, ST_OK},
        '{8'h02, 8'd44, 16'hFFFF,  16'hFFFF, 8'h00, 6'd44, 1'b1, 2'd1, 2'd0, FILL_ONES, 1'b0, ST_OK},
        '{8'h02, 8'd44, 16'd47,    16'h0001, 8'h00, 6'd44, 1'b0, 2'd0, 2'd0, FILL_RAND, 1'b1,
          ST_BAD_PLEN},
        '{8'h00, 8'd44, 16'd100,   16'h0000, 8'h00, 6'd44, 1'b0, 2'd0, 2'd0, FILL_RAND, 1'b1,
          ST_BAD_START},
        '{8'hFF, 8'd44, 16'd100,   16'h0000, 8'h00, 6'd44, 1'b1, 2'd0, 2'd0, FILL_RAND, 1'b1,
          ST_BAD_START},
        '{8'h02, 8'd43, 16'd100,   16'h0000, 8'h00, 6'd44, 1'b0, 2'd0, 2'd0, FILL_RAND, 1'b1,
          ST_BAD_HLEN},
        '{8'h02, 8'd44, 16'd100,   16'h0000, 8'h80, 6'd44, 1'b0, 2'd0, 2'd0, FILL_RAND, 1'b1,
          ST_BAD_SUM},
        '{8'h02, 8'd44, 16'd100,   16'h0000, 8'h00, 6'd1,  1'b1, 2'd0, 2'd0, FILL_RAND, 1'b1,
          ST_SHORT},
        '{8'h02, 8'd44, 16'd100,   16'h0000, 8'h00, 6'd43, 1'b1, 2'd0, 2'd0, FILL_RAND, 1'b1,
          ST_SHORT},
        '{8'h02, 8'd44, 16'd100,   16'h0000, 8'h00, 6'd20, 1'b0, 2'd0, 2'd0, FILL_RAND, 1'b0, ST_OK},
        '{8'h02, 8'd44, 16'd46,    16'h0002, 8'h00, 6'd44, 1'b1, 2'd3, 2'd0, FILL_RAND, 1'b0, ST_OK},
        '{8'hFF, 8'hFF, 16'd100,   16'h0000, 8'h00, 6'd44, 1'b0, 2'd0, 2'd0, FILL_RAND, 1'b1,
          ST_BAD_START},
        '{8'h02, 8'd44, 16'd10,    16'h0000, 8'h01, 6'd44, 1'b0, 2'd0, 2'd0, FILL_RAND, 1'b1,
          ST_BAD_SUM},
        '{8'h02, 8'd0,  16'd100,   16'h0000, 8'h01, 6'd44, 1'b0, 2'd0, 2'd0, FILL_RAND, 1'b1,
          ST_BAD_HLEN},
        '{8'h02, 8'd44, 16'd0,     16'h0000, 8'h00, 6'd44, 1'b0, 2'd0, 2'd0, FILL_RAND, 1'b1,
          ST_BAD_PLEN}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_first_byte = 1'b0;
    logic        i_last_byte = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_status;
    logic [15:0] o_pkt_len;
    logic [7:0]  o_proto_ver;
    logic [15:0] o_frame_opt;
    logic [63:0] o_dest_address;
    logic [39:0] o_source_address;
    logic [31:0] o_frame_number;
    logic [31:0] o_access_code;
    logic [15:0] o_command_word;
    logic [23:0] o_item_word;
    logic [63:0] o_block_info;
    logic [15:0] o_payload_length;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'h0;
    logic [31:0] pwdata = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    logic [7:0]  cfg_start = 8'h02;
    logic [15:0] cfg_mask = 16'h0001;
    int          hdr_pos = 0;
    bit          hdr_done = 1'b1;
    logic [7:0]  hdr_xor = 8'h00;
    logic [7:0]  hdr_store [HDR_BYTES];

    logic [7:0]  frame_bytes [HDR_BYTES];
    t_fields     pending_headers [$];
    t_fields     want_hdr;
    bit          use_typed = 1'b0;
    t_status     typed_status = ST_OK;
    int          snd_idle = 0;
    int          rcv_idle = 0;
    int          n_bytes = 0;
    int          n_pushed = 0;
    int          results_seen = 0;
    int          n_settings = 0;
    int          err_count = 0;

    frame_header_parser i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_data_byte        (i_data_byte),
        .i_first_byte       (i_first_byte),
        .i_last_byte        (i_last_byte),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_status           (o_status),
        .o_pkt_len          (o_pkt_len),
        .o_proto_ver        (o_proto_ver),
        .o_frame_opt        (o_frame_opt),
        .o_dest_address     (o_dest_address),
        .o_source_address   (o_source_address),
        .o_frame_number     (o_frame_number),
        .o_access_code      (o_access_code),
        .o_command_word     (o_command_word),
        .o_item_word        (o_item_word),
        .o_block_info       (o_block_info),
        .o_payload_length   (o_payload_length),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #(2_000_000);
        $display("frame_header_parser_tb: errors");
        $finish;
    end

    function automatic logic [63:0] gather(input int from, input int count);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < count; i++) v = {v[55:0], hdr_store[from + i]};
        return v;
    endfunction

    function automatic t_fields header_result();
        t_fields     r;
        logic [15:0] plen;
        logic [15:0] fopt;
        int          tail;
        r = '0;
        plen = 16'(gather(1, 2));
        fopt = 16'(gather(4, 2));
        tail = ((fopt & cfg_mask) != 0) ? TAIL_LONG : TAIL_SHORT;
        if (hdr_store[0] != cfg_start) begin
            r.status = ST_BAD_START;
        end else if (hdr_store[6] != 8'(HDR_BYTES)) begin
            r.status = ST_BAD_HLEN;
        end else if (hdr_xor != hdr_store[SUM_BYTES]) begin
            r.status = ST_BAD_SUM;
        end else if (int'(plen) < HDR_BYTES + tail) begin
            r.status = ST_BAD_PLEN;
        end else begin
            r.status = ST_OK;
        end
        if (r.status != ST_OK) return r;
        r.pkt_len = plen;
        r.proto_ver = hdr_store[3];
        r.frame_opt = fopt;
        r.dest_address = gather(7, 8);
        r.source_address = 40'(gather(15, 5));
        r.frame_number = 32'(gather(20, 4));
        r.access_code = 32'(gather(24, 4));
        r.command_word = 16'(gather(29, 2));
        r.item_word = 24'(gather(33, 3));
        r.block_info = gather(36, 8);
        r.payload_length = 16'(int'(plen) - HDR_BYTES - tail);
        return r;
    endfunction

    function automatic bit predict_header(input logic [7:0] b, input bit f, input bit l,
                                          output t_fields r);
        r = '0;
        if (f) begin
            hdr_pos = 0;
            hdr_xor = 8'h00;
            hdr_done = 1'b0;
        end
        if (hdr_done) return 1'b0;
        hdr_store[hdr_pos] = b;
        if (hdr_pos < SUM_BYTES) hdr_xor ^= b;
        hdr_pos++;
        if (hdr_pos < HDR_BYTES && !l) return 1'b0;
        hdr_done = 1'b1;
        if (hdr_pos < HDR_BYTES) begin
            r.status = ST_SHORT;
        end else begin
            r = header_result();
        end
        return 1'b1;
    endfunction

    task automatic report_error(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] exp);
        if (got !== exp) report_error($sformatf("%s got %0h, expected %0h", name, got, exp));
    endtask

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= rcv_idle);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (pending_headers.size() == 0) begin
                report_error("header result with nothing pending");
            end else begin
                want_hdr = pending_headers.pop_front();
                check_field("status", 64'(o_status), 64'(want_hdr.status));
                check_field("pkt_len", 64'(o_pkt_len), 64'(want_hdr.pkt_len));
                check_field("proto_ver", 64'(o_proto_ver), 64'(want_hdr.proto_ver));
                check_field("frame_opt", 64'(o_frame_opt), 64'(want_hdr.frame_opt));
                check_field("dest_address", o_dest_address, want_hdr.dest_address);
                check_field("source_address", 64'(o_source_address),
                            64'(want_hdr.source_address));
                check_field("frame_number", 64'(o_frame_number), 64'(want_hdr.frame_number));
                check_field("access_code", 64'(o_access_code), 64'(want_hdr.access_code));
                check_field("command_word", 64'(o_command_word), 64'(want_hdr.command_word));
                check_field("item_word", 64'(o_item_word), 64'(want_hdr.item_word));
                check_field("block_info", o_block_info, want_hdr.block_info);
                check_field("payload_length", 64'(o_payload_length),
                            64'(want_hdr.payload_length));
            end
        end
    end

    task automatic put_byte(input logic [7:0] b, input bit f, input bit l);
        t_fields res;
        while ($urandom_range(99) < snd_idle) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= b;
        i_first_byte <= f;
        i_last_byte <= l;
        do @(posedge i_clk); while (!o_ready);
        n_bytes++;
        if (predict_header(b, f, l, res)) begin
            if (use_typed) begin
                res = '0;
                res.status = typed_status;
            end
            pending_headers.push_back(res);
            n_pushed++;
        end
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_headers.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == REG_START_BYTE) begin
            cfg_start = data[7:0];
        end else if (addr == REG_CHECK_MASK) begin
            cfg_mask = data[15:0];
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic run_row(input t_buf_row r);
        logic [7:0] x;
        for (int i = 0; i < HDR_BYTES; i++) begin
            case (r.fill)
                FILL_ZERO: frame_bytes[i] = 8'h00;
                FILL_ONES: frame_bytes[i] = 8'hFF;
                default:   frame_bytes[i] = 8'($urandom);
            endcase
        end
        frame_bytes[0] = r.b0;
        frame_bytes[1] = r.plen[15:8];
        frame_bytes[2] = r.plen[7:0];
        frame_bytes[4] = r.fopt[15:8];
        frame_bytes[5] = r.fopt[7:0];
        frame_bytes[6] = r.hlen;
        x = 8'h00;
        for (int i = 0; i < SUM_BYTES; i++) x ^= frame_bytes[i];
        frame_bytes[SUM_BYTES] = x ^ r.flip;
        use_typed = r.typed;
        typed_status = r.status;
        repeat (r.lead) put_byte(8'($urandom), 1'b0, 1'($urandom_range(1)));
        for (int i = 0; i < r.len; i++) begin
            put_byte(frame_bytes[i], i == 0, r.mark_last && i == int'(r.len) - 1);
        end
        repeat (r.trail) put_byte(8'($urandom), 1'b0, 1'($urandom_range(1)));
    endtask

    function automatic t_buf_row random_row();
        t_buf_row r;
        int       pick;
        int       tail;
        r.b0 = cfg_start;
        r.hlen = 8'(HDR_BYTES);
        r.fopt = 16'($urandom);
        r.flip = 8'h00;
        r.len = 6'(HDR_BYTES);
        r.mark_last = 1'($urandom_range(1));
        r.trail = 2'($urandom_range(3));
        r.lead = 2'd0;
        r.fill = FILL_RAND;
        r.typed = 1'b0;
        r.status = ST_OK;
        tail = ((r.fopt & cfg_mask) != 0) ? TAIL_LONG : TAIL_SHORT;
        case ($urandom_range(2))
            0:       r.plen = 16'(HDR_BYTES + tail);
            1:       r.plen = 16'hFFFF;
            default: r.plen = 16'($urandom_range(65535, HDR_BYTES + tail));
        endcase
        pick = $urandom_range(99);
        if (pick >= 92) begin
            r.len = 6'd0;
            r.trail = 2'd0;
            r.lead = 2'($urandom_range(3, 1));
        end else if (pick >= 88) begin
            r.len = 6'($urandom_range(HDR_BYTES - 1, 1));
            r.mark_last = 1'b0;
            r.trail = 2'd0;
        end else if (pick >= 80) begin
            r.len = 6'($urandom_range(HDR_BYTES - 1, 1));
            r.mark_last = 1'b1;
        end else if (pick >= 74) begin
            r.flip = 8'($urandom_range(255, 1));
        end else if (pick >= 68) begin
            r.hlen = 8'(HDR_BYTES) ^ 8'($urandom_range(255, 1));
        end else if (pick >= 62) begin
            r.b0 = cfg_start ^ 8'($urandom_range(255, 1));
        end else if (pick >= 56) begin
            r.plen = 16'($urandom_range(HDR_BYTES + tail - 1, 0));
        end
        return r;
    endfunction

    initial begin
        logic [7:0]  cs;
        logic [15:0] cm;
        int          seg_bytes;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        snd_idle = 24;
        rcv_idle = 68;
        for (int k = 0; k < $size(DIR_ROWS); k++) run_row(DIR_ROWS[k]);
        use_typed = 1'b0;
        for (int seg = 0; seg < 6; seg++) begin
            snd_idle = (seg < 2) ? 24 : (seg < 4) ? 68 : 0;
            rcv_idle = (seg < 2) ? 68 : (seg < 4) ? 24 : 0;
            case (seg)
                0: begin cs = 8'h02; cm = 16'h0001; end
                1: begin cs = 8'hFF; cm = 16'hFFFF; end
                2: begin cs = 8'h00; cm = 16'h0000; end
                3: begin cs = 8'h55; cm = 16'h8000; end
                default: begin
                    cs = 8'($urandom);
                    cm = 16'($urandom);
                end
            endcase
            drain_results();
            apb_write(REG_START_BYTE, {24'h0, cs});
            apb_write(REG_CHECK_MASK, {16'h0, cm});
            n_settings++;
            seg_bytes = n_bytes;
            while (n_bytes - seg_bytes < 50) begin
                if ($urandom_range(24) == 0) drain_results();
                run_row(random_row());
            end
        end
        drain_results();
        $display("summary: %0d bytes sent, %0d header results checked, %0d register settings",
                 n_bytes, results_seen, n_settings);
        if (err_count == 0) begin
            $display("frame_header_parser_tb: clean");
        end else begin
            $display("frame_header_parser_tb: errors");
        end
        $finish;
    end

endmodule
